FILE: sv/iirdf1_pkg.sv
// ----------------------------------------------------------------------------
// iirdf1_pkg
// Shared constants for the direct form I IIR filter: defaults, coefficient
// format and register map.
// ----------------------------------------------------------------------------
`default_nettype none

package iirdf1_pkg;

	localparam int TAPS_DEF         = 4;
	localparam int SAMPLE_WIDTH_DEF = 16;

	localparam int COUNT_W   = 8;   // period count field
	localparam int COEF_W    = 18;  // Q4.14 coefficients
	localparam int FRAC_BITS = 14;
	localparam int REG_TAPS  = 4;   // taps that have coefficient registers

	localparam int NUM_REGS = 7;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;
	localparam int IDX_W    = 3;

	// register map: b0..b3 then a1..a3
	localparam logic [IDX_W-1:0] REG_B0 = 3'd0;
	localparam logic [IDX_W-1:0] REG_A1 = 3'd4;

	localparam logic signed [COEF_W-1:0] COEF_B0_RST = 18'sd16384;

endpackage

`default_nettype wire

FILE: sv/iirdf1_in_if.sv
// ----------------------------------------------------------------------------
// iirdf1_in_if
// Input sample channel: valid/ready with sample and period count.
// ----------------------------------------------------------------------------
`default_nettype none

interface iirdf1_in_if #(
	parameter int SAMPLE_WIDTH = iirdf1_pkg::SAMPLE_WIDTH_DEF
);
	logic                                 valid;
	logic                                 ready;
	logic signed [SAMPLE_WIDTH-1:0]       sample;
	logic        [iirdf1_pkg::COUNT_W-1:0] period_count;

	modport source (output valid, output sample, output period_count, input ready);
	modport sink   (input valid, input sample, input period_count, output ready);
endinterface

`default_nettype wire

FILE: sv/iirdf1_out_if.sv
// ----------------------------------------------------------------------------
// iirdf1_out_if
// Result channel: valid/ready with filtered output and saturation flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface iirdf1_out_if #(
	parameter int SAMPLE_WIDTH = iirdf1_pkg::SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] filtered;
	logic                           saturated;

	modport source (output valid, output filtered, output saturated, input ready);
	modport sink   (input valid, input filtered, input saturated, output ready);
endinterface

`default_nettype wire

FILE: sv/iir_direct_form_one_filter_top.sv
// ----------------------------------------------------------------------------
// iir_direct_form_one_filter_top
// Direct form I IIR filter with one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Each input transfer runs max(period_count,1) filter steps: the held previous
// sample for all but the last step, the new sample for the last. A step, with
// NB = min(TAPS,4), is a history shift, then 2*NB-1 coefficient/history
// products fed one per cycle through the single registered multiplier, an
// add of the last product, and a round and saturate. After the last step the
// result register loads once it is free. The input is not ready while an item
// is in flight; the result register lets the next item start while a result
// waits. Coefficients are Q4.14 APB registers at byte address 4*i (b0..b3,
// a1..a3), to be written only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module iir_direct_form_one_filter_top #(
	parameter int TAPS         = iirdf1_pkg::TAPS_DEF,
	parameter int SAMPLE_WIDTH = iirdf1_pkg::SAMPLE_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	iirdf1_in_if.sink                          in_ch,
	iirdf1_out_if.source                       out_ch,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [iirdf1_pkg::ADDR_W-1:0] paddr,
	input  wire logic [iirdf1_pkg::DATA_W-1:0] pwdata,
	output logic      [iirdf1_pkg::DATA_W-1:0] prdata,
	output logic                               pready
);
	import iirdf1_pkg::*;

	localparam int NB      = (TAPS < REG_TAPS) ? TAPS : REG_TAPS;
	localparam int NTERM   = 2 * NB - 1;
	localparam int TERM_W  = $clog2(NTERM);
	localparam int PROD_W  = COEF_W + SAMPLE_WIDTH;
	localparam int ACC_W   = PROD_W + 4;
	localparam int QW      = ACC_W - FRAC_BITS;
	localparam logic [TERM_W-1:0] LAST_TERM = TERM_W'(NTERM - 1);
	localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [QW-1:0] Q_HI = QW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
	localparam logic signed [QW-1:0] Q_LO = -Q_HI - QW'(1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SHIFT, ST_MAC, ST_ADD, ST_ROUND, ST_FINISH
	} state_t;

	// ---------------- configuration registers ----------------
	logic signed [COEF_W-1:0] coef_q [NUM_REGS];
	logic        [IDX_W-1:0]  widx;

	assign widx   = paddr[ADDR_W-1:2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				coef_q[i] <= (IDX_W'(i) == REG_B0) ? COEF_B0_RST : '0;
		end else if (psel && penable && pwrite && pready) begin
			for (int i = 0; i < NUM_REGS; i++)
				if (widx == IDX_W'(i)) coef_q[i] <= pwdata[COEF_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		for (int i = 0; i < NUM_REGS; i++)
			if (widx == IDX_W'(i))
				prdata = {{(DATA_W-COEF_W){coef_q[i][COEF_W-1]}}, coef_q[i]};
	end

	// ---------------- datapath and sequencer ----------------
	state_t                         state_q;
	logic signed [SAMPLE_WIDTH-1:0] xh_q [TAPS];
	logic signed [SAMPLE_WIDTH-1:0] yh_q [TAPS];
	logic signed [SAMPLE_WIDTH-1:0] sample_q;
	logic signed [SAMPLE_WIDTH-1:0] held_q;
	logic        [COUNT_W-1:0]      steps_q;
	logic        [TERM_W-1:0]       term_q;
	logic                           clip_q;
	logic signed [ACC_W-1:0]        acc_q;
	logic signed [PROD_W-1:0]       prod_s1;
	logic                           sub_s1;
	logic                           pvld_s1;
	logic                           out_vld_q;
	logic signed [SAMPLE_WIDTH-1:0] out_y_q;
	logic                           out_sat_q;

	logic signed [COEF_W-1:0]       mul_coef;
	logic signed [SAMPLE_WIDTH-1:0] mul_data;
	logic signed [PROD_W-1:0]       mul_prod;
	logic signed [ACC_W-1:0]        prod_ext;
	logic signed [ACC_W-1:0]        addend;
	logic signed [ACC_W-1:0]        rnd_sum;
	logic signed [QW-1:0]           q_full;
	logic signed [SAMPLE_WIDTH-1:0] q_sat;
	logic                           q_clip;
	logic signed [SAMPLE_WIDTH-1:0] x_new;
	logic                           out_free;

	// term order: b0..b(NB-1) on inputs, then a1..a(NB-1) on outputs
	always_comb begin
		mul_coef = '0;
		mul_data = '0;
		for (int k = 0; k < NB; k++)
			if (term_q == TERM_W'(k)) begin
				mul_coef = coef_q[REG_B0 + IDX_W'(k)];
				mul_data = xh_q[k];
			end
		for (int k = 1; k < NB; k++)
			if (term_q == TERM_W'(NB - 1 + k)) begin
				mul_coef = coef_q[REG_A1 + IDX_W'(k - 1)];
				mul_data = yh_q[k];
			end
	end

	assign mul_prod = mul_coef * mul_data;
	assign prod_ext = {{(ACC_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
	assign addend   = pvld_s1 ? (sub_s1 ? -prod_ext : prod_ext) : '0;

	// round half up, then floor shift
	assign rnd_sum = acc_q + RND;
	assign q_full  = rnd_sum[ACC_W-1:FRAC_BITS];

	always_comb begin
		q_clip = 1'b0;
		q_sat  = q_full[SAMPLE_WIDTH-1:0];
		if (q_full > Q_HI) begin
			q_sat  = Q_HI[SAMPLE_WIDTH-1:0];
			q_clip = 1'b1;
		end else if (q_full < Q_LO) begin
			q_sat  = Q_LO[SAMPLE_WIDTH-1:0];
			q_clip = 1'b1;
		end
	end

	assign x_new    = (steps_q == COUNT_W'(1)) ? sample_q : held_q;
	assign out_free = !out_vld_q || out_ch.ready;

	assign in_ch.ready      = (state_q == ST_IDLE);
	assign out_ch.valid     = out_vld_q;
	assign out_ch.filtered  = out_y_q;
	assign out_ch.saturated = out_sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			sample_q  <= '0;
			held_q    <= '0;
			steps_q   <= '0;
			term_q    <= '0;
			clip_q    <= 1'b0;
			acc_q     <= '0;
			prod_s1   <= '0;
			sub_s1    <= 1'b0;
			pvld_s1   <= 1'b0;
			out_vld_q <= 1'b0;
			out_y_q   <= '0;
			out_sat_q <= 1'b0;
			for (int k = 0; k < TAPS; k++) begin
				xh_q[k] <= '0;
				yh_q[k] <= '0;
			end
		end else begin
			// result register: loads in finish, drains on a result transfer
			out_vld_q <= (state_q == ST_FINISH && out_free) || (out_vld_q && !out_ch.ready);
			pvld_s1   <= (state_q == ST_MAC);
			acc_q     <= (state_q == ST_SHIFT) ? '0 : acc_q + addend;
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						sample_q <= in_ch.sample;
						held_q   <= xh_q[0];
						steps_q  <= (in_ch.period_count == '0) ? COUNT_W'(1)
						                                       : in_ch.period_count;
						clip_q   <= 1'b0;
						state_q  <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					for (int k = TAPS - 1; k > 0; k--) begin
						xh_q[k] <= xh_q[k-1];
						yh_q[k] <= yh_q[k-1];
					end
					xh_q[0] <= x_new;
					yh_q[0] <= '0;
					term_q  <= '0;
					state_q <= ST_MAC;
				end
				ST_MAC: begin
					prod_s1 <= mul_prod;
					sub_s1  <= (term_q >= TERM_W'(NB));
					if (term_q == LAST_TERM) state_q <= ST_ADD;
					else term_q <= term_q + TERM_W'(1);
				end
				ST_ADD: begin
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					yh_q[0] <= q_sat;
					clip_q  <= clip_q | q_clip;
					if (steps_q == COUNT_W'(1)) begin
						state_q <= ST_FINISH;
					end else begin
						steps_q <= steps_q - COUNT_W'(1);
						state_q <= ST_SHIFT;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_y_q   <= yh_q[0];
						out_sat_q <= clip_q;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------- assertions ----------------
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("input ready while an item is in flight");

	a_steps_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (steps_q != '0))
		else $error("step counter is zero while busy");

	a_term_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) |-> (term_q <= LAST_TERM))
		else $error("term index out of range");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == ST_FINISH))
		else $error("result register loaded outside finish");

	a_last_product: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD) |-> pvld_s1)
		else $error("last product missing before rounding");

endmodule

`default_nettype wire
